FILE: rtl/core/bbsra_pkg.sv
// bbsra_pkg: field widths, op and status codes, register indexes and the
// command/response structs between the allocator core and its bad-chunk map.
// No dependencies.
package bbsra_pkg;

    localparam int unsigned PTR_W      = 17;  // ring pointer and chunk count
    localparam int unsigned IDX_W      = 16;
    localparam int unsigned DSS_W      = 40;
    localparam int unsigned SPC_W      = 17;
    localparam int unsigned PROD_W     = PTR_W + SPC_W;
    localparam int unsigned SUM_W      = 41;
    localparam int unsigned OFF_W      = 50;
    localparam int unsigned SECTOR_SH  = 9;   // 512-byte sectors
    localparam int unsigned EPOCH_W    = 32;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 40;
    localparam int unsigned ROW_BITS   = 32;  // map bits per memory row
    localparam int unsigned SEL_W      = 5;

    localparam logic [PTR_W-1:0] RING_LIMIT = 17'h1FFFF;
    localparam logic [SPC_W-1:0] SPC_RESET  = 17'd16384;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_MARK  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_NOSPACE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_TOTAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_FULL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_START  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SECT_CHUNK  = 2'd3;

    typedef struct packed {
        logic             rd;     // read the row holding chunk
        logic             wr;     // set the bit of chunk in the row read last cycle
        logic [PTR_W-1:0] chunk;
    } t_map_cmd;

    typedef struct packed {
        logic ready;    // clearing pass done
        logic bit_val;  // bad bit of the chunk read last cycle
    } t_map_rsp;

endpackage

FILE: rtl/core/bbsra_map.sv
// bbsra_map: bad-chunk bitmap held in a row-wide synchronous memory, with
// registered read, read-modify-write bit set and a clearing pass after reset.
// Depends on bbsra_pkg.
module bbsra_map #(
    parameter int unsigned MAX_CHUNKS = 65536
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bbsra_pkg::t_map_cmd i_cmd,
    output bbsra_pkg::t_map_rsp o_rsp
);

    localparam int unsigned ROWS   = (MAX_CHUNKS + bbsra_pkg::ROW_BITS - 1) / bbsra_pkg::ROW_BITS;
    localparam int unsigned ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int unsigned CW     = ROW_AW + bbsra_pkg::SEL_W;
    localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(ROWS - 1);

    logic [bbsra_pkg::ROW_BITS-1:0] mem [ROWS];

    logic [bbsra_pkg::ROW_BITS-1:0] r_rd_data;
    logic [bbsra_pkg::SEL_W-1:0]    r_sel;
    logic                           r_clearing;
    logic [ROW_AW-1:0]              r_clr_row;

    logic [CW-1:0]                  chunk_ext;
    logic [ROW_AW-1:0]              row;
    logic [bbsra_pkg::SEL_W-1:0]    sel;
    logic                           wr_en;
    logic [ROW_AW-1:0]              wr_row;
    logic [bbsra_pkg::ROW_BITS-1:0] wr_data;

    assign chunk_ext = CW'(i_cmd.chunk);
    assign row       = chunk_ext[CW-1:bbsra_pkg::SEL_W];
    assign sel       = i_cmd.chunk[bbsra_pkg::SEL_W-1:0];

    // the clearing pass owns the write port until it finishes
    assign wr_en   = r_clearing | i_cmd.wr;
    assign wr_row  = r_clearing ? r_clr_row : row;
    assign wr_data = r_clearing ? '0
                   : (r_rd_data | (bbsra_pkg::ROW_BITS'(1) << sel));

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_row] <= wr_data;
        end
        if (i_cmd.rd) begin
            r_rd_data <= mem[row];
            r_sel     <= sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_row  <= '0;
        end else if (r_clearing) begin
            if (r_clr_row == LAST_ROW) begin
                r_clearing <= 1'b0;
            end
            r_clr_row <= r_clr_row + ROW_AW'(1);
        end
    end

    assign o_rsp.ready   = ~r_clearing;
    assign o_rsp.bit_val = r_rd_data[r_sel];

endmodule

FILE: rtl/core/bad_block_skipping_ring_allocator_unit.sv
// Ring allocator top level: allocate, mark-bad and query over a bad-chunk bitmap.
// Accept to result beat: allocate visits S_ALLOC_RD then S_ALLOC_CHK per chunk tried,
// then S_ADD; no space ends in S_ALLOC_RD; mark and query pass S_IDX_CHK; empty ring,
// out of range or unused op answer straight from the accept. One command at a time, the
// next start taken on the result beat; the receiver cannot stall the result. After reset
// the map is cleared one 32-chunk row a cycle with busy high. Depends on bbsra_pkg.
module bad_block_skipping_ring_allocator_unit #(
    parameter int unsigned MAX_CHUNKS = 65536
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          i_op,
    input  logic [bbsra_pkg::IDX_W-1:0]         i_chunk_index,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bbsra_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bbsra_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                                o_done,
    output logic [1:0]                          o_status,
    output logic [bbsra_pkg::IDX_W-1:0]         o_granted_chunk,
    output logic [bbsra_pkg::OFF_W-1:0]         o_byte_offset,
    output logic                                o_chunk_is_bad,
    output logic [bbsra_pkg::PTR_W-1:0]         o_bad_count,
    output logic [bbsra_pkg::EPOCH_W-1:0]       o_wrap_epoch,
    output logic                                o_has_wrapped
);

    localparam logic [bbsra_pkg::PTR_W-1:0] RING_CAP =
        (MAX_CHUNKS > 131071) ? bbsra_pkg::RING_LIMIT : bbsra_pkg::PTR_W'(MAX_CHUNKS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC_RD,
        S_ALLOC_CHK,
        S_ADD,
        S_IDX_CHK
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [bbsra_pkg::PTR_W-1:0]   r_chunk_total;
    logic                          r_stop;
    logic [bbsra_pkg::DSS_W-1:0]   r_dss;
    logic [bbsra_pkg::SPC_W-1:0]   r_spc;

    // allocator state
    logic [bbsra_pkg::PTR_W-1:0]   r_wp, n_wp;
    logic [bbsra_pkg::EPOCH_W-1:0] r_epoch, n_epoch;
    logic [bbsra_pkg::PTR_W-1:0]   r_bad_total, n_bad_total;
    logic [bbsra_pkg::PTR_W-1:0]   r_tried, n_tried;
    logic [bbsra_pkg::PTR_W-1:0]   r_cand, n_cand;
    logic [bbsra_pkg::PROD_W-1:0]  r_prod, n_prod;
    logic [1:0]                    r_op, n_op;
    logic [bbsra_pkg::IDX_W-1:0]   r_idx, n_idx;

    // result beat
    logic                          r_done, n_done;
    logic [1:0]                    r_status, n_status;
    logic [bbsra_pkg::IDX_W-1:0]   r_granted, n_granted;
    logic [bbsra_pkg::OFF_W-1:0]   r_offset, n_offset;
    logic                          r_isbad, n_isbad;

    logic [bbsra_pkg::PTR_W-1:0]   total;
    logic [bbsra_pkg::PTR_W-1:0]   wp_inc;
    logic [bbsra_pkg::SUM_W-1:0]   sector_sum;
    logic                          accept;

    bbsra_pkg::t_map_cmd map_cmd;
    bbsra_pkg::t_map_rsp map_rsp;

    bbsra_map #(
        .MAX_CHUNKS(MAX_CHUNKS)
    ) u_map (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (map_cmd),
        .o_rsp  (map_rsp)
    );

    assign total      = (r_chunk_total > RING_CAP) ? RING_CAP : r_chunk_total;
    assign wp_inc     = r_wp + bbsra_pkg::PTR_W'(1);
    assign sector_sum = bbsra_pkg::SUM_W'(r_dss) + bbsra_pkg::SUM_W'(r_prod);
    assign busy       = (r_state != S_IDLE) | ~map_rsp.ready;
    assign accept     = start & ~busy;

    always_comb begin
        n_state     = r_state;
        n_wp        = r_wp;
        n_epoch     = r_epoch;
        n_bad_total = r_bad_total;
        n_tried     = r_tried;
        n_cand      = r_cand;
        n_prod      = r_prod;
        n_op        = r_op;
        n_idx       = r_idx;
        n_done      = 1'b0;
        n_status    = r_status;
        n_granted   = r_granted;
        n_offset    = r_offset;
        n_isbad     = r_isbad;
        map_cmd     = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op      = i_op;
                    n_idx     = i_chunk_index;
                    n_status  = bbsra_pkg::ST_OK;
                    n_granted = '0;
                    n_offset  = '0;
                    n_isbad   = 1'b0;
                    case (i_op)
                        bbsra_pkg::OP_ALLOC: begin
                            if (total == '0) begin
                                n_done   = 1'b1;
                                n_status = bbsra_pkg::ST_NOSPACE;
                            end else begin
                                // pointer left beyond a shrunk ring counts as a lap end
                                if (!r_stop && (r_wp >= total)) begin
                                    n_wp    = '0;
                                    n_epoch = r_epoch + bbsra_pkg::EPOCH_W'(1);
                                end
                                n_tried = '0;
                                n_state = S_ALLOC_RD;
                            end
                        end
                        bbsra_pkg::OP_MARK, bbsra_pkg::OP_QUERY: begin
                            if (bbsra_pkg::PTR_W'(i_chunk_index) >= total) begin
                                n_done   = 1'b1;
                                n_status = bbsra_pkg::ST_RANGE;
                            end else begin
                                map_cmd.rd    = 1'b1;
                                map_cmd.chunk = bbsra_pkg::PTR_W'(i_chunk_index);
                                n_state       = S_IDX_CHK;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_ALLOC_RD: begin
                if ((r_tried == total) || (r_stop && (r_wp >= total))) begin
                    n_done   = 1'b1;
                    n_status = bbsra_pkg::ST_NOSPACE;
                    n_state  = S_IDLE;
                end else begin
                    map_cmd.rd    = 1'b1;
                    map_cmd.chunk = r_wp;
                    n_cand        = r_wp;
                    n_tried       = r_tried + bbsra_pkg::PTR_W'(1);
                    if (!r_stop && (wp_inc >= total)) begin
                        n_wp    = '0;
                        n_epoch = r_epoch + bbsra_pkg::EPOCH_W'(1);
                    end else begin
                        n_wp = wp_inc;
                    end
                    n_state = S_ALLOC_CHK;
                end
            end
            S_ALLOC_CHK: begin
                if (map_rsp.bit_val) begin
                    n_state = S_ALLOC_RD;
                end else begin
                    n_prod  = bbsra_pkg::PROD_W'(r_cand) * bbsra_pkg::PROD_W'(r_spc);
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                n_done    = 1'b1;
                n_granted = r_cand[bbsra_pkg::IDX_W-1:0];
                n_offset  = {sector_sum, {bbsra_pkg::SECTOR_SH{1'b0}}};
                n_state   = S_IDLE;
            end
            S_IDX_CHK: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
                if (r_op == bbsra_pkg::OP_MARK) begin
                    if (!map_rsp.bit_val) begin
                        map_cmd.wr    = 1'b1;
                        map_cmd.chunk = bbsra_pkg::PTR_W'(r_idx);
                        n_bad_total   = r_bad_total + bbsra_pkg::PTR_W'(1);
                    end
                end else begin
                    n_isbad = map_rsp.bit_val;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_wp          <= '0;
            r_epoch       <= bbsra_pkg::EPOCH_W'(1);
            r_bad_total   <= '0;
            r_done        <= 1'b0;
            r_chunk_total <= '0;
            r_stop        <= 1'b0;
            r_dss         <= '0;
            r_spc         <= bbsra_pkg::SPC_RESET;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_epoch     <= n_epoch;
            r_bad_total <= n_bad_total;
            r_done      <= n_done;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    bbsra_pkg::CFG_CHUNK_TOTAL: r_chunk_total <= i_cfg_data[bbsra_pkg::PTR_W-1:0];
                    bbsra_pkg::CFG_STOP_FULL:   r_stop        <= i_cfg_data[0];
                    bbsra_pkg::CFG_DATA_START:  r_dss         <= i_cfg_data[bbsra_pkg::DSS_W-1:0];
                    bbsra_pkg::CFG_SECT_CHUNK:  r_spc         <= i_cfg_data[bbsra_pkg::SPC_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
        // working and result payload registers
        r_tried   <= n_tried;
        r_cand    <= n_cand;
        r_prod    <= n_prod;
        r_op      <= n_op;
        r_idx     <= n_idx;
        r_status  <= n_status;
        r_granted <= n_granted;
        r_offset  <= n_offset;
        r_isbad   <= n_isbad;
    end

    assign o_cfg_ready     = 1'b1;
    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_granted_chunk = r_granted;
    assign o_byte_offset   = r_offset;
    assign o_chunk_is_bad  = r_isbad;
    // counters only move while a command runs, so they read post-step on the result beat
    assign o_bad_count     = r_bad_total;
    assign o_wrap_epoch    = r_epoch;
    assign o_has_wrapped   = (r_epoch > bbsra_pkg::EPOCH_W'(1));

endmodule
